### rtl/psd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and constants for the point-to-segment distance pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;

  // Width of the distance result and of the threshold
  localparam int SPAN_W = 17;

  // Where the closest point of the segment lies
  typedef enum logic [1:0] {
    MODE_START,
    MODE_FINISH,
    MODE_RATIO
  } mode_t;

endpackage

### rtl/psd_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_div_cell
// One restoring-division cell: shifts the partial remainder, tries the
// divisor and appends one quotient bit. Payload rides along unchanged.
// ----------------------------------------------------------------------------
module psd_div_cell #(
  parameter int RW = 35,
  parameter int QW = 16,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vin,
  input  logic [RW-1:0] rem_in,
  input  logic [RW-1:0] den_in,
  input  logic [QW-1:0] quo_in,
  input  logic [PW-1:0] pay_in,
  output logic          vout,
  output logic [RW-1:0] rem,
  output logic [RW-1:0] den,
  output logic [QW-1:0] quo,
  output logic [PW-1:0] pay
);

  logic [RW-1:0] rem2;

  assign rem2 = {rem_in[RW-2:0], 1'b0};

  // Advance valid
  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  // Try one quotient bit
  always_ff @(posedge clk) begin
    if (en) begin
      den <= den_in;
      pay <= pay_in;
      if (rem2 >= den_in) begin
        rem <= rem2 - den_in;
        quo <= {quo_in[QW-2:0], 1'b1};
      end else begin
        rem <= rem2;
        quo <= {quo_in[QW-2:0], 1'b0};
      end
    end
  end

endmodule

### rtl/psd_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_sqrt_cell
// One digit-by-digit square root cell: brings down two radicand bits and
// decides one root bit. The threshold rides along unchanged.
// ----------------------------------------------------------------------------
module psd_sqrt_cell #(
  parameter int VW = 36,
  parameter int RTW = 18,
  parameter int PW = 17
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           vin,
  input  logic [VW-1:0]  val_in,
  input  logic [RTW+1:0] rem_in,
  input  logic [RTW-1:0] root_in,
  input  logic [PW-1:0]  pay_in,
  output logic           vout,
  output logic [VW-1:0]  val,
  output logic [RTW+1:0] rem,
  output logic [RTW-1:0] root,
  output logic [PW-1:0]  pay
);

  logic [RTW+1:0] rem_sh;
  logic [RTW+1:0] trial;

  assign rem_sh = {rem_in[RTW-1:0], val_in[VW-1:VW-2]};
  assign trial  = {root_in, 2'b01};

  // Advance valid
  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  // Decide one root bit
  always_ff @(posedge clk) begin
    if (en) begin
      val <= {val_in[VW-3:0], 2'b00};
      pay <= pay_in;
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root_in[RTW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root_in[RTW-2:0], 1'b0};
      end
    end
  end

endmodule

### rtl/point_segment_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_segment_distance
// Distance from a point to a line segment, with a nearness flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall carry one request of a query point,
//   the segment start and finish, and a threshold. A request is taken at a
//   rising edge with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall carry span (floor of the distance)
//   and is_near (span <= threshold).
//   Throughput: one request per cycle while the output is not stalled. The pipeline is a row of cells:
//   RATIO_BITS division cells, one per quotient bit, and COORD_BITS+2 root
//   cells, one per root bit, between a few multiply and add stages.
//   Order: difference, product and division-head stages, division cells,
//   scale, residual, square and root-head stages, root cells, output register.
//   Stall: while out_valid is high and out_stall is high, the whole pipeline
//   holds and in_stall is raised; the result stays on the outputs.
//   Reset: rst clears every valid bit; no request is in flight afterwards.
// ----------------------------------------------------------------------------
module point_segment_distance #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 4,
  parameter int RATIO_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [COORD_BITS-1:0]         point_x,
  input  logic signed [COORD_BITS-1:0]         point_y,
  input  logic signed [COORD_BITS-1:0]         start_x,
  input  logic signed [COORD_BITS-1:0]         start_y,
  input  logic signed [COORD_BITS-1:0]         finish_x,
  input  logic signed [COORD_BITS-1:0]         finish_y,
  input  logic [psd_pkg::SPAN_W-1:0]           threshold,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [psd_pkg::SPAN_W-1:0]           span,
  output logic                                 is_near
);

  localparam int C    = COORD_BITS;
  localparam int R    = RATIO_BITS;
  localparam int SW   = psd_pkg::SPAN_W;
  localparam int RW   = 2 * C + 3;
  localparam int PRW  = C + R + 2;
  localparam int VW   = 2 * C + 4;
  localparam int RTW  = C + 2;
  localparam int N    = C + 2;
  // mode, six coordinates, two deltas, threshold
  localparam int DPW  = 2 + 6 * C + 2 * (C + 1) + SW;
  localparam logic signed [PRW-1:0] HALF = PRW'(1) <<< (R - 1);
  // unit size of one coordinate LSB is 2^-FRAC_BITS; arithmetic is unit-free
  localparam int UNIT_SHIFT = FRAC_BITS;

  logic en;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage 1: differences
  logic                  v1;
  logic signed [C:0]     dx1, dy1, ex1, ey1;
  logic signed [C-1:0]   px1, py1, sx1, sy1, fx1, fy1;
  logic [SW-1:0]         thr1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1  <= (C+1)'(finish_x) - (C+1)'(start_x);
      dy1  <= (C+1)'(finish_y) - (C+1)'(start_y);
      ex1  <= (C+1)'(point_x) - (C+1)'(start_x);
      ey1  <= (C+1)'(point_y) - (C+1)'(start_y);
      px1  <= point_x;
      py1  <= point_y;
      sx1  <= start_x;
      sy1  <= start_y;
      fx1  <= finish_x;
      fy1  <= finish_y;
      thr1 <= threshold;
    end
  end

  // Stage 2: products for length and projection
  logic                  v2;
  logic signed [2*C+1:0] sqx2, sqy2, pex2, pey2;
  logic signed [C:0]     dx2, dy2;
  logic signed [C-1:0]   px2, py2, sx2, sy2, fx2, fy2;
  logic [SW-1:0]         thr2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx2 <= dx1 * dx1;
      sqy2 <= dy1 * dy1;
      pex2 <= ex1 * dx1;
      pey2 <= ey1 * dy1;
      dx2  <= dx1;
      dy2  <= dy1;
      px2  <= px1;
      py2  <= py1;
      sx2  <= sx1;
      sy2  <= sy1;
      fx2  <= fx1;
      fy2  <= fy1;
      thr2 <= thr1;
    end
  end

  // Stage 3: length, numerator and clamp decision
  logic [2*C+1:0]        len_w;
  logic signed [2*C+2:0] num_w;
  psd_pkg::mode_t        mode_w;

  assign len_w = $unsigned(sqx2) + $unsigned(sqy2);
  assign num_w = (2*C+3)'(pex2) + (2*C+3)'(pey2);

  always_comb begin
    if (len_w == '0 || num_w <= 0) begin
      mode_w = psd_pkg::MODE_START;
    end else if (num_w >= $signed({1'b0, len_w})) begin
      mode_w = psd_pkg::MODE_FINISH;
    end else begin
      mode_w = psd_pkg::MODE_RATIO;
    end
  end

  logic          dv   [0:R];
  logic [RW-1:0] drem [0:R];
  logic [RW-1:0] dden [0:R];
  logic [R-1:0]  dquo [0:R];
  logic [DPW-1:0] dpay [0:R];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      drem[0] <= num_w[RW-1:0];
      dden[0] <= {1'b0, len_w};
      dquo[0] <= '0;
      dpay[0] <= {mode_w, px2, py2, sx2, sy2, fx2, fy2, dx2, dy2, thr2};
    end
  end

  // Division cells: one ratio bit each
  for (genvar i = 0; i < R; i++) begin : g_div
    psd_div_cell #(.RW(RW), .QW(R), .PW(DPW)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .vin    (dv[i]),
      .rem_in (drem[i]),
      .den_in (dden[i]),
      .quo_in (dquo[i]),
      .pay_in (dpay[i]),
      .vout   (dv[i+1]),
      .rem    (drem[i+1]),
      .den    (dden[i+1]),
      .quo    (dquo[i+1]),
      .pay    (dpay[i+1])
    );
  end

  // Unpack divider payload
  logic [1:0]          dmode;
  logic signed [C-1:0] dpx, dpy, dsx, dsy, dfx, dfy;
  logic signed [C:0]   ddx, ddy;
  logic [SW-1:0]       dthr;

  assign {dmode, dpx, dpy, dsx, dsy, dfx, dfy, ddx, ddy, dthr} = dpay[R];

  // Stage M: scale the deltas by the ratio
  logic                  vm;
  logic signed [PRW-1:0] mx, my;
  psd_pkg::mode_t        modem;
  logic signed [C-1:0]   pxm, pym, sxm, sym, fxm, fym;
  logic [SW-1:0]         thrm;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (en) begin
      vm <= dv[R];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx    <= ddx * $signed({1'b0, dquo[R]});
      my    <= ddy * $signed({1'b0, dquo[R]});
      modem <= psd_pkg::mode_t'(dmode);
      pxm   <= dpx;
      pym   <= dpy;
      sxm   <= dsx;
      sym   <= dsy;
      fxm   <= dfx;
      fym   <= dfy;
      thrm  <= dthr;
    end
  end

  // Stage C: round, pick the closest point, form the residual
  logic signed [PRW-1:0] shx, shy;
  logic signed [C:0]     cx, cy;

  assign shx = (mx + HALF) >>> R;
  assign shy = (my + HALF) >>> R;

  always_comb begin
    case (modem)
      psd_pkg::MODE_RATIO: begin
        cx = (C+1)'(sxm) + shx[C:0];
        cy = (C+1)'(sym) + shy[C:0];
      end
      psd_pkg::MODE_FINISH: begin
        cx = (C+1)'(fxm);
        cy = (C+1)'(fym);
      end
      default: begin
        cx = (C+1)'(sxm);
        cy = (C+1)'(sym);
      end
    endcase
  end

  logic                vc;
  logic signed [C+1:0] rxc, ryc;
  logic [SW-1:0]       thrc;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rxc  <= (C+2)'(pxm) - (C+2)'(cx);
      ryc  <= (C+2)'(pym) - (C+2)'(cy);
      thrc <= thrm;
    end
  end

  // Stage Q: squares of the residual
  logic                  vq;
  logic signed [VW-1:0]  sqxq, sqyq;
  logic [SW-1:0]         thrq;

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= 1'b0;
    end else if (en) begin
      vq <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqxq <= rxc * rxc;
      sqyq <= ryc * ryc;
      thrq <= thrc;
    end
  end

  // Stage D: squared distance, head of the root chain
  logic           sv    [0:N];
  logic [VW-1:0]  sval  [0:N];
  logic [RTW+1:0] srem  [0:N];
  logic [RTW-1:0] sroot [0:N];
  logic [SW-1:0]  spay  [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (en) begin
      sv[0] <= vq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sval[0]  <= $unsigned(sqxq) + $unsigned(sqyq);
      srem[0]  <= '0;
      sroot[0] <= '0;
      spay[0]  <= thrq;
    end
  end

  // Square root cells: one root bit each
  for (genvar j = 0; j < N; j++) begin : g_sqrt
    psd_sqrt_cell #(.VW(VW), .RTW(RTW), .PW(SW)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .vin     (sv[j]),
      .val_in  (sval[j]),
      .rem_in  (srem[j]),
      .root_in (sroot[j]),
      .pay_in  (spay[j]),
      .vout    (sv[j+1]),
      .val     (sval[j+1]),
      .rem     (srem[j+1]),
      .root    (sroot[j+1]),
      .pay     (spay[j+1])
    );
  end

  // Output register
  logic [SW-1:0] root_s;

  assign root_s = SW'(sroot[N]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sv[N] && (UNIT_SHIFT >= 0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      span    <= root_s;
      is_near <= root_s <= spay[N];
    end
  end

endmodule

### rtl/psd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks for the point-to-segment distance block.
// ----------------------------------------------------------------------------
module psd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [psd_pkg::SPAN_W-1:0] span,
  input logic                       is_near
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(span) && $stable(is_near))
    else $error("stalled result changed");

  // Drop results after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Stall the input only while the output is blocked
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output blockage");

  // Advance the pipeline when no result is waiting
  a_drain: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with no result waiting");

endmodule

bind point_segment_distance psd_checker u_psd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .span      (span),
  .is_near   (is_near)
);

### tb/sv/tb_point_segment_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_segment_distance
// Drives point/segment requests with random gaps and stalls, predicts the
// distance and nearness flag per request, and checks every result in order.
// ----------------------------------------------------------------------------
module tb_point_segment_distance;

  typedef struct {
    logic signed [15:0] px, py, sx, sy, fx, fy;
    logic [psd_pkg::SPAN_W-1:0] thr;
  } seg_req_t;

  typedef struct {
    logic [psd_pkg::SPAN_W-1:0] span;
    logic                       near;
  } dist_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] point_x = '0, point_y = '0, start_x = '0, start_y = '0;
  logic signed [15:0] finish_x = '0, finish_y = '0;
  logic [psd_pkg::SPAN_W-1:0] threshold = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [psd_pkg::SPAN_W-1:0] span;
  logic is_near;

  seg_req_t  pending_reqs[$];
  dist_res_t expected_dists[$];
  int  errors = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;
  bit  hold_off = 1'b0;
  bit  in_taken = 1'b0;
  int  in_gap = 0;
  int  out_gap = 0;

  point_segment_distance dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Integer square root, floor
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Predict distance from point to clamped projection on segment
  function automatic dist_res_t seg_distance(seg_req_t r);
    longint dx, dy, ex, ey, len, num, cx, cy, rx, ry, t;
    longint unsigned d2;
    dist_res_t res;
    dx = longint'(r.fx) - longint'(r.sx);
    dy = longint'(r.fy) - longint'(r.sy);
    ex = longint'(r.px) - longint'(r.sx);
    ey = longint'(r.py) - longint'(r.sy);
    len = dx * dx + dy * dy;
    cx = r.sx;
    cy = r.sy;
    if (len > 0) begin
      num = ex * dx + ey * dy;
      if (num >= len) begin
        cx = r.fx;
        cy = r.fy;
      end else if (num > 0) begin
        t = (num <<< 16) / len;
        // arithmetic shift gives floor for either sign
        cx = r.sx + ((dx * t + 32768) >>> 16);
        cy = r.sy + ((dy * t + 32768) >>> 16);
      end
    end
    rx = r.px - cx;
    ry = r.py - cy;
    d2 = longint'(rx * rx) + longint'(ry * ry);
    res.span = 17'(root_floor(d2) & 64'h1FFFF);
    res.near = (res.span <= r.thr);
    return res;
  endfunction

  function automatic logic signed [15:0] rand_coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 64)) - 16'sd32;
      default: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
    endcase
  endfunction

  task automatic add_req(logic signed [15:0] px, py, sx, sy, fx, fy,
                         logic [psd_pkg::SPAN_W-1:0] thr);
    seg_req_t r;
    r.px = px; r.py = py; r.sx = sx; r.sy = sy; r.fx = fx; r.fy = fy; r.thr = thr;
    pending_reqs.push_back(r);
  endtask

  // Driver: present the head request, hold it until accepted
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_taken) begin
        if (in_gap > 0) in_gap--;
        else if (!quiet && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 5);
        if (pending_reqs.size() > 0 && in_gap == 0 && !hold_off) begin
          in_valid <= 1'b1;
          point_x <= pending_reqs[0].px;
          point_y <= pending_reqs[0].py;
          start_x <= pending_reqs[0].sx;
          start_y <= pending_reqs[0].sy;
          finish_x <= pending_reqs[0].fx;
          finish_y <= pending_reqs[0].fy;
          threshold <= pending_reqs[0].thr;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (out_gap > 0) out_gap--;
      else if (!quiet && $urandom_range(0, 9) == 0) out_gap = $urandom_range(1, 5);
      out_stall <= (out_gap > 0);
    end
  end

  // Monitor: compare each result with the oldest prediction, log accepted requests
  always @(posedge clk) begin
    dist_res_t e;
    cycles++;
    if (!rst && out_valid && !out_stall) begin
      if (expected_dists.size() == 0) begin
        $error("unexpected result span=%0d is_near=%0d", span, is_near);
        errors++;
      end else begin
        e = expected_dists.pop_front();
        if (span !== e.span) begin
          $error("span expected %0d actual %0d", e.span, span);
          errors++;
        end
        if (is_near !== e.near) begin
          $error("is_near expected %0d actual %0d", e.near, is_near);
          errors++;
        end
      end
    end
    in_taken = !rst && in_valid && !in_stall;
    if (in_taken) begin
      expected_dists.push_back(seg_distance(pending_reqs.pop_front()));
    end
    if (cycles > 400000) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int mode;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, zero-length segment, clamping, threshold edges
    add_req(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 17'h1FFFF);
    add_req(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 17'd0);
    add_req(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 17'd92682);
    add_req(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 17'd0);
    add_req(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 17'd0);
    add_req(16'sd5, 16'sd7, 16'sd3, 16'sd3, 16'sd3, 16'sd3, 17'd4);
    add_req(-16'sd100, 16'sd0, 16'sd0, 16'sd0, 16'sd50, 16'sd0, 17'd100);
    add_req(16'sd200, 16'sd3, 16'sd0, 16'sd0, 16'sd50, 16'sd0, 17'd150);
    add_req(16'sd200, 16'sd3, 16'sd0, 16'sd0, 16'sd50, 16'sd0, 17'd149);
    add_req(16'sd25, 16'sd40, 16'sd0, 16'sd0, 16'sd50, 16'sd0, 17'd40);
    add_req(16'sd25, 16'sd40, 16'sd0, 16'sd0, 16'sd50, 16'sd0, 17'd39);
    add_req(16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd3, 16'sd2, 17'd0);
    add_req(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 17'h10000);
    add_req(-16'sd1, -16'sd1, 16'sh8000, 16'sd0, 16'sh7FFF, 16'sd1, 17'h0FFFF);
    add_req(16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555, 16'sh5555, 16'shAAAA, 17'h15555);
    add_req(-16'sd3, 16'sd2, 16'sd1, -16'sd1, -16'sd1, 16'sd1, 17'h0AAAA);
    while (pending_reqs.size() > 0 || expected_dists.size() > 0) @(posedge clk);

    // Random: mixes of wide, local and extreme coordinates
    for (int i = 0; i < 950; i++) begin
      seg_req_t r;
      mode = $urandom_range(0, 5);
      if (mode > 2) mode = 0;
      r.px = rand_coord(mode); r.py = rand_coord(mode);
      r.sx = rand_coord(mode); r.sy = rand_coord(mode);
      if ($urandom_range(0, 15) == 0) begin
        r.fx = r.sx; r.fy = r.sy;
      end else begin
        r.fx = rand_coord(mode); r.fy = rand_coord(mode);
      end
      r.thr = ($urandom_range(0, 3) == 0) ? 17'($urandom) : 17'($urandom_range(0, 92682));
      pending_reqs.push_back(r);
      if (i == 300) begin
        // hold the sender until the pipeline drains
        while (pending_reqs.size() > 0) @(posedge clk);
        hold_off = 1'b1;
        while (expected_dists.size() > 0) @(posedge clk);
        hold_off = 1'b0;
      end
      if (i == 800) quiet = 1'b1;
    end

    while (pending_reqs.size() > 0 || expected_dists.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

### point_segment_distance.f
rtl/psd_pkg.sv
rtl/psd_div_cell.sv
rtl/psd_sqrt_cell.sv
rtl/point_segment_distance.sv
rtl/psd_checker.sv
tb/sv/tb_point_segment_distance.sv
